>>> sv/sft_pkg.sv
// sft_pkg: shared types and constants of the SSE field tokenizer.
// Holds the result record, kind/phase/match codes, byte codes and the name-match tables.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sft_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int VCOUNT_W       = 16;

    // result kinds
    localparam logic [1:0] KIND_VALUE    = 2'd0;
    localparam logic [1:0] KIND_END      = 2'd1;
    localparam logic [1:0] KIND_DISPATCH = 2'd2;

    // line phase
    localparam logic [1:0] PH_NAME  = 2'd0;
    localparam logic [1:0] PH_SKIP  = 2'd1;
    localparam logic [1:0] PH_VALUE = 2'd2;

    // name match candidates
    localparam logic [2:0] M_START = 3'd0;
    localparam logic [2:0] M_ID    = 3'd1;
    localparam logic [2:0] M_EVENT = 3'd2;
    localparam logic [2:0] M_DATA  = 3'd3;
    localparam logic [2:0] M_NONE  = 3'd4;

    // bytes with a meaning
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_D     = 8'h64;

    typedef struct packed {
        logic [1:0]          kind;
        logic [1:0]          field;
        logic [7:0]          data;
        logic [VCOUNT_W-1:0] count;
    } t_result;

    // length of the candidate name
    function automatic logic [2:0] cand_len(input logic [2:0] m);
        logic [2:0] len;
        case (m)
            M_ID:    len = 3'd2;
            M_EVENT: len = 3'd5;
            M_DATA:  len = 3'd4;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    // expected byte at position pos of the candidate name
    function automatic logic [7:0] cand_char(input logic [2:0] m, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (m)
            M_ID: begin
                case (pos)
                    3'd0:    ch = "i";
                    3'd1:    ch = "d";
                    default: ch = 8'h00;
                endcase
            end
            M_EVENT: begin
                case (pos)
                    3'd0:    ch = "e";
                    3'd1:    ch = "v";
                    3'd2:    ch = "e";
                    3'd3:    ch = "n";
                    3'd4:    ch = "t";
                    default: ch = 8'h00;
                endcase
            end
            M_DATA: begin
                case (pos)
                    3'd0:    ch = "d";
                    3'd1:    ch = "a";
                    3'd2:    ch = "t";
                    3'd3:    ch = "a";
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

>>> sv/sft_in_reg.sv
// sft_in_reg: input register of the tokenizer, one byte deep.
// Plain valid/stall register; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sft_in_reg (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    input  wire  [7:0] i_byte,
    output logic       o_stall,
    output logic       o_valid,
    output logic [7:0] o_byte,
    input  wire        i_take
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic       load;

    // full and not drained this cycle
    assign o_stall = r_valid & ~i_take;
    assign load    = i_valid & ~o_stall;
    assign n_valid = load | (r_valid & ~i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule
`default_nettype wire

>>> sv/sft_parse.sv
// sft_parse: line state and per-byte tokenizing logic.
// Depends on sft_pkg for codes, the result record and the name tables.
`timescale 1ns / 1ps
`default_nettype none
module sft_parse
    import sft_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    input  wire  [7:0] i_byte,
    input  wire        i_out_ready,
    output logic       o_take,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam logic [VCOUNT_W-1:0] VCOUNT_MAX = '1;

    logic [1:0]            r_phase, n_phase;
    logic                  r_empty, n_empty;
    logic [2:0]            r_match, n_match;
    logic [2:0]            r_pos,   n_pos;
    logic [COUNT_BITS-1:0] r_len,   n_len;

    logic                  emit;
    logic                  name_done;
    logic                  known;
    logic [VCOUNT_W-1:0]   len_out;
    t_result               res;

    assign name_done = (r_match != M_START) && (r_match != M_NONE)
                       && (r_pos == cand_len(r_match));
    assign known     = (r_phase == PH_NAME) ? name_done : (r_match != M_NONE);

    // saturate the value length into the result count field
    assign len_out = ({{VCOUNT_W{1'b0}}, r_len} > {{COUNT_BITS{1'b0}}, VCOUNT_MAX})
                     ? VCOUNT_MAX : VCOUNT_W'(r_len);

    always_comb begin
        n_phase = r_phase;
        n_empty = r_empty;
        n_match = r_match;
        n_pos   = r_pos;
        n_len   = r_len;
        emit    = 1'b0;
        res     = '0;
        if (i_byte == CH_LF) begin
            if (r_empty) begin
                emit     = 1'b1;
                res.kind = KIND_DISPATCH;
            end else if (known) begin
                emit      = 1'b1;
                res.kind  = KIND_END;
                res.field = r_match[1:0] - 2'd1;
                res.count = len_out;
            end
            n_phase = PH_NAME;
            n_empty = 1'b1;
            n_match = M_START;
            n_pos   = 3'd0;
            n_len   = '0;
        end else if (i_byte != CH_CR) begin
            n_empty = 1'b0;
            if (r_phase == PH_NAME) begin
                if (i_byte == CH_COLON) begin
                    if (!name_done) begin
                        n_match = M_NONE;
                    end
                    n_phase = PH_SKIP;
                end else if (r_match == M_START) begin
                    case (i_byte)
                        CH_I:    n_match = M_ID;
                        CH_E:    n_match = M_EVENT;
                        CH_D:    n_match = M_DATA;
                        default: n_match = M_NONE;
                    endcase
                    n_pos = 3'd1;
                end else if (r_match != M_NONE) begin
                    if ((r_pos < cand_len(r_match)) && (i_byte == cand_char(r_match, r_pos))) begin
                        n_pos = r_pos + 3'd1;
                    end else begin
                        n_match = M_NONE;
                    end
                end
            end else if (!((r_phase == PH_SKIP) && (i_byte == CH_SPACE))) begin
                n_phase = PH_VALUE;
                if (r_match != M_NONE) begin
                    emit      = 1'b1;
                    res.kind  = KIND_VALUE;
                    res.field = r_match[1:0] - 2'd1;
                    res.data  = i_byte;
                    if (r_len != '1) begin
                        n_len = r_len + COUNT_BITS'(1);
                    end
                end
            end
        end
    end

    // a byte with no result never waits for the output side
    assign o_take      = i_valid & (~emit | i_out_ready);
    assign o_res_valid = o_take & emit;
    assign o_res       = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NAME;
            r_empty <= 1'b1;
            r_match <= M_START;
            r_pos   <= 3'd0;
            r_len   <= '0;
        end else if (o_take) begin
            r_phase <= n_phase;
            r_empty <= n_empty;
            r_match <= n_match;
            r_pos   <= n_pos;
            r_len   <= n_len;
        end
    end

    a_dispatch_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.kind == KIND_DISPATCH))
        |=> (r_empty && (r_phase == PH_NAME) && (r_len == '0)))
        else $error("line state not cleared after dispatch");

    a_len_in_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len != '0) |-> ((r_phase == PH_VALUE) && (r_match != M_NONE)
                           && (r_match != M_START)))
        else $error("value length counted outside a known value");

    a_value_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.kind == KIND_VALUE))
        |-> ((r_match == M_ID) || (r_match == M_EVENT) || (r_match == M_DATA)))
        else $error("value byte emitted for unknown field");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_match == M_ID) || (r_match == M_EVENT) || (r_match == M_DATA))
        |-> (r_pos <= cand_len(r_match)))
        else $error("name position past candidate length");

endmodule
`default_nettype wire

>>> sv/sft_out_reg.sv
// sft_out_reg: result register of the tokenizer with valid/stall handshake.
// Depends on sft_pkg for the result record.
`timescale 1ns / 1ps
`default_nettype none
module sft_out_reg
    import sft_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_load,
    input  t_result i_res,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_res,
    input  wire     i_stall
);

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    // free, or being taken this cycle
    assign o_ready = ~r_valid | ~i_stall;
    assign n_valid = i_load | (r_valid & i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule
`default_nettype wire

>>> sv/sse_field_tokenizer.sv
// sse_field_tokenizer: Server-Sent Events field tokenizer, one byte per cycle
// while no result waits on an output stall. An accepted byte is held in the
// input register, taken by the line-state update in sft_parse, and its
// request loaded into the result register. Reset (i_rst_n low, synchronous)
// empties both registers and returns the line state to start of field name.
// Depends on sft_pkg, sft_in_reg, sft_parse and sft_out_reg.
`timescale 1ns / 1ps
`default_nettype none
module sse_field_tokenizer
    import sft_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // input byte channel
    input  wire                 i_in_valid,
    input  wire  [7:0]          i_in_byte,
    output logic                o_in_stall,
    // result channel
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output logic [1:0]          o_kind,
    output logic [1:0]          o_field,
    output logic [7:0]          o_out_byte,
    output logic [VCOUNT_W-1:0] o_value_count
);

    // input register -> parse
    logic       s_valid;
    logic [7:0] s_byte;
    logic       s_take;

    // parse -> result register
    logic       out_ready;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    // Stage 1: hold one byte. It drains whenever the parse step takes it,
    // so a new byte enters in the same cycle.
    sft_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_byte  (i_in_byte),
        .o_stall (o_in_stall),
        .o_valid (s_valid),
        .o_byte  (s_byte),
        .i_take  (s_take)
    );

    // Stage 2: per-byte line-state update. CR, name bytes, skipped spaces
    // and bytes of unknown fields produce no request and are taken even
    // while the result register is held by a stall.
    sft_parse #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_valid),
        .i_byte      (s_byte),
        .i_out_ready (out_ready),
        .o_take      (s_take),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register: reloads while empty or in the cycle its request is taken.
    sft_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .o_ready (out_ready),
        .o_valid (o_out_valid),
        .o_res   (out_res),
        .i_stall (i_out_stall)
    );

    assign o_kind        = out_res.kind;
    assign o_field       = out_res.field;
    assign o_out_byte    = out_res.data;
    assign o_value_count = out_res.count;

endmodule
`default_nettype wire

>>> bench/sft_token_checker.sv
// sft_token_checker: predicts and checks the tokens of sse_field_tokenizer.
// Watches both request channels and keeps its own copy of the line state.
// Depends on sft_pkg for the result record and byte/kind/match codes.
`timescale 1ns / 1ps
module sft_token_checker
    import sft_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire  [7:0]          i_in_byte,
    input  wire                 i_in_stall,
    input  wire                 i_out_valid,
    input  wire                 i_out_stall,
    input  wire  [1:0]          i_kind,
    input  wire  [1:0]          i_field,
    input  wire  [7:0]          i_out_byte,
    input  wire  [VCOUNT_W-1:0] i_value_count,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked
);

    // line state of the predictor
    logic [1:0]            phase_q;
    logic                  empty_q;
    logic [2:0]            match_q;
    logic [2:0]            pos_q;
    logic [COUNT_BITS-1:0] vlen_q;

    t_result expected_tokens[$];
    t_result want;
    int      errors  = 0;
    int      checked = 0;

    function automatic string known_name(input logic [2:0] m);
        case (m)
            M_ID:    return "id";
            M_EVENT: return "event";
            default: return "data";
        endcase
    endfunction

    function automatic logic name_done();
        string nm;
        nm = known_name(match_q);
        return (match_q == M_ID || match_q == M_EVENT || match_q == M_DATA) &&
               (pos_q == nm.len());
    endfunction

    task automatic clear_line();
        phase_q = PH_NAME;
        empty_q = 1'b1;
        match_q = M_START;
        pos_q   = 3'd0;
        vlen_q  = '0;
    endtask

    task automatic push_token(input logic [1:0] kind, input logic [1:0] field,
                              input logic [7:0] data, input logic [VCOUNT_W-1:0] count);
        t_result r;
        r.kind  = kind;
        r.field = field;
        r.data  = data;
        r.count = count;
        expected_tokens.push_back(r);
    endtask

    task automatic match_name_byte(input logic [7:0] c);
        string nm;
        if (match_q == M_START) begin
            case (c)
                CH_I:    match_q = M_ID;
                CH_E:    match_q = M_EVENT;
                CH_D:    match_q = M_DATA;
                default: match_q = M_NONE;
            endcase
            pos_q = 3'd1;
        end else if (match_q != M_NONE) begin
            nm = known_name(match_q);
            if (pos_q < nm.len() && c == nm[pos_q]) begin
                pos_q = pos_q + 3'd1;
            end else begin
                match_q = M_NONE;
            end
        end
    endtask

    task automatic predict_byte(input logic [7:0] c);
        logic                known;
        logic [VCOUNT_W-1:0] cnt;
        if (c == CH_CR) begin
            return;
        end
        if (c == CH_LF) begin
            if (empty_q) begin
                clear_line();
                push_token(KIND_DISPATCH, 2'd0, 8'd0, '0);
                return;
            end
            known = (phase_q == PH_NAME) ? name_done() : (match_q != M_NONE);
            if (known) begin
                cnt = (vlen_q > {VCOUNT_W{1'b1}}) ? {VCOUNT_W{1'b1}} : vlen_q;
                push_token(KIND_END, match_q[1:0] - 2'd1, 8'd0, cnt);
            end
            clear_line();
            return;
        end
        empty_q = 1'b0;
        if (phase_q == PH_NAME) begin
            if (c == CH_COLON) begin
                if (!name_done()) begin
                    match_q = M_NONE;
                end
                phase_q = PH_SKIP;
            end else begin
                match_name_byte(c);
            end
            return;
        end
        if (phase_q == PH_SKIP) begin
            if (c == CH_SPACE) begin
                return;
            end
            phase_q = PH_VALUE;
        end
        if (match_q == M_NONE) begin
            return;
        end
        if (vlen_q != '1) begin
            vlen_q = vlen_q + 1'b1;
        end
        push_token(KIND_VALUE, match_q[1:0] - 2'd1, c, '0);
    endtask

    task automatic compare_field(input string what, input logic [15:0] exp_v,
                                 input logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
            errors++;
        end
    endtask

    // results are compared before the new byte is predicted; a byte never
    // comes out in the cycle it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_line();
            expected_tokens.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_tokens.size() == 0) begin
                    $display("%0t: unexpected request, expected none, actual kind %0d field %0d byte %0d count %0d",
                             $time, i_kind, i_field, i_out_byte, i_value_count);
                    errors++;
                end else begin
                    want = expected_tokens.pop_front();
                    compare_field("kind", want.kind, i_kind);
                    compare_field("field", want.field, i_field);
                    compare_field("out_byte", want.data, i_out_byte);
                    compare_field("value_count", want.count, i_value_count);
                    checked++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_byte(i_in_byte);
            end
        end
        o_fail_count <= errors;
        o_pending    <= expected_tokens.size();
        o_checked    <= checked;
    end

endmodule

>>> bench/tb_sse_field_tokenizer.sv
// tb_sse_field_tokenizer: stimulus and verdict for sse_field_tokenizer.
// Drives byte requests, stalls the result side, checks via sft_token_checker.
// Depends on sft_pkg, sse_field_tokenizer and sft_token_checker.
`timescale 1ns / 1ps
module tb_sse_field_tokenizer;
    import sft_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;   // cycles with no request moving
    localparam int HOLD_CYCLES    = 120;    // long result-side hold-off
    localparam int LONG_VALUE     = 40;     // longest data value of the run

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_in_valid    = 1'b0;
    logic [7:0]          i_in_byte     = 8'd0;
    logic                i_out_stall   = 1'b0;
    logic                o_in_stall;
    logic                o_out_valid;
    logic [1:0]          o_kind;
    logic [1:0]          o_field;
    logic [7:0]          o_out_byte;
    logic [VCOUNT_W-1:0] o_value_count;

    int fail_count;
    int pending;
    int checked;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int bytes_sent    = 0;
    int quiet_cycles  = 0;

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    sse_field_tokenizer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_byte     (i_in_byte),
        .o_in_stall    (o_in_stall),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_field       (o_field),
        .o_out_byte    (o_out_byte),
        .o_value_count (o_value_count)
    );

    sft_token_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_byte     (i_in_byte),
        .i_in_stall    (o_in_stall),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_kind        (o_kind),
        .i_field       (o_field),
        .i_out_byte    (o_out_byte),
        .i_value_count (o_value_count),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    // Result side. A new hold request from the stimulus starts a long
    // hold-off counted here; otherwise stall at the current idle rate.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall  <= 1'b0;
            hold_left    <= 0;
            holds_served <= 0;
        end else if (holds_served != hold_requests) begin
            holds_served <= hold_requests;
            hold_left    <= HOLD_CYCLES - 1;
            i_out_stall  <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: a run that stops moving requests on both sides is hung.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog, no request moved for %0d cycles", $time,
                         WATCHDOG_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // One byte request: optional idle cycles with valid low, then hold the
    // byte until an edge sees it with no stall. Valid is left high so the
    // next call can follow back to back.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    // line end, sometimes as CR LF
    task automatic end_line();
        if ($urandom_range(3) == 0) begin
            send_byte(CH_CR);
        end
        send_byte(CH_LF);
    endtask

    // value bytes: anything but LF, with spaces and CRs sprinkled in
    task automatic send_value(input int n);
        logic [7:0] b;
        repeat (n) begin
            b = 8'($urandom_range(255));
            if (b == CH_LF) begin
                b = CH_COLON;
            end
            if ($urandom_range(15) == 0) begin
                b = CH_SPACE;
            end
            send_byte(b);
        end
    endtask

    function automatic string field_name(input int k);
        case (k)
            0:       return "id";
            1:       return "event";
            default: return "data";
        endcase
    endfunction

    // Mostly well-formed field lines; the rest are dispatches, comments,
    // near-miss names and raw noise.
    task automatic send_random_line();
        int    shape;
        int    k;
        string nm;
        shape = $urandom_range(99);
        if (shape < 55) begin
            send_text(field_name($urandom_range(2)));
            if ($urandom_range(9) != 0) begin
                send_byte(CH_COLON);
                repeat ($urandom_range(3)) send_byte(CH_SPACE);
                send_value($urandom_range(12));
            end
            end_line();
        end else if (shape < 70) begin
            end_line();
        end else if (shape < 80) begin
            send_byte(CH_COLON);
            send_value($urandom_range(6));
            end_line();
        end else if (shape < 90) begin
            nm = field_name($urandom_range(2));
            case ($urandom_range(2))
                0: nm = nm.substr(0, nm.len() - 2);
                1: nm = {nm, "s"};
                default: begin
                    k = $urandom_range(nm.len() - 1);
                    nm[k] = nm[k] ^ 8'h20;
                end
            endcase
            send_text(nm);
            send_byte(CH_COLON);
            send_value($urandom_range(6));
            end_line();
        end else begin
            repeat ($urandom_range(8, 1)) send_byte(8'($urandom_range(255)));
        end
    endtask

    // park the sender until every expected token is out
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct <= 22;
        recv_idle_pct <= 49;
        @(posedge i_clk);

        // Directed: dispatch with nothing before it, data value with a
        // skipped space, extreme bytes, a later colon and a NUL, a known
        // name with no colon across a dropped CR, a comment, an empty
        // event value, then a dispatch after fields.
        send_byte(CH_LF);
        send_text("data: ");
        send_byte(8'hFF);
        send_byte(CH_COLON);
        send_byte(8'h00);
        send_byte(CH_LF);
        send_text("id");
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(CH_COLON);
        send_byte(CH_LF);
        send_text("event");
        send_byte(CH_COLON);
        send_byte(CH_LF);
        send_byte(CH_LF);

        while (bytes_sent < 300) send_random_line();
        // sender pauses with everything delivered
        drain();

        send_idle_pct <= 49;
        recv_idle_pct <= 22;
        while (bytes_sent < 600) send_random_line();

        // full rate; a long result-side hold-off fills the block while
        // bytes keep coming, so the input stalls
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        hold_requests <= hold_requests + 1;
        while (bytes_sent < 800) send_random_line();

        // one longer data value, then a dispatch
        send_text("data:");
        repeat (LONG_VALUE) send_byte(8'($urandom_range(255, 33)));
        send_byte(CH_LF);
        send_byte(CH_LF);

        drain();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d bytes over three idle mixes, incl. a %0d-byte data value.",
                 bytes_sent, LONG_VALUE);
        $display("Checked %0d tokens, with one %0d-cycle result hold-off.",
                 checked, HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
